### src/wtvm_pkg.sv
// ----------------------------------------------------------------------------
// wtvm_pkg
// Shared types, constants and the pitch-bend multiplier table of the
// wavetable voice mixer.
// ----------------------------------------------------------------------------
package wtvm_pkg;

  localparam int VOICE_COUNT = 15;
  localparam int VOICE_W     = $clog2(VOICE_COUNT);
  localparam int WAVE_SIZE   = 1024;
  localparam int WAVE_AW     = $clog2(WAVE_SIZE);
  localparam int NOTE_COUNT  = 128;
  localparam int NOTE_AW     = $clog2(NOTE_COUNT);
  localparam int INC_W       = 26;
  // phase is 10.16 with WAVE_AW integer bits, so the wrap is a plain truncation
  localparam int PHASE_W     = WAVE_AW + 16;
  localparam int VOL_W       = 7;
  localparam int MULT_W      = 17;
  localparam int SUM_W       = 24;

  localparam logic [10:0] WAVE_LIMIT = 11'(WAVE_SIZE);
  localparam logic [10:0] NOTE_LIMIT = 11'(NOTE_COUNT);

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_NOTE_ON   = 3'd1,
    CMD_NOTE_OFF  = 3'd2,
    CMD_BEND      = 3'd3,
    CMD_LOAD_WAVE = 3'd4,
    CMD_LOAD_STEP = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NOTE_ON,
    S_REL,
    S_BEND_RD,
    S_BEND_MUL,
    S_BEND_WR,
    S_TICK_RD,
    S_TICK_PH,
    S_TICK_ACC,
    S_TICK_OUT
  } state_t;

  typedef struct packed {
    logic [VOL_W-1:0]   vol;
    logic [INC_W-1:0]   inc;
    logic [PHASE_W-1:0] phase;
  } voice_t;

  function automatic logic [MULT_W-1:0] bend_mult(input logic [5:0] idx);
    logic [MULT_W-1:0] m;
    case (idx)
      6'd0:  m = 17'd61858; 6'd1:  m = 17'd61970; 6'd2:  m = 17'd62081;
      6'd3:  m = 17'd62194; 6'd4:  m = 17'd62306; 6'd5:  m = 17'd62419;
      6'd6:  m = 17'd62531; 6'd7:  m = 17'd62644; 6'd8:  m = 17'd62757;
      6'd9:  m = 17'd62871; 6'd10: m = 17'd62984; 6'd11: m = 17'd63098;
      6'd12: m = 17'd63212; 6'd13: m = 17'd63326; 6'd14: m = 17'd63441;
      6'd15: m = 17'd63556; 6'd16: m = 17'd63670; 6'd17: m = 17'd63785;
      6'd18: m = 17'd63901; 6'd19: m = 17'd64016; 6'd20: m = 17'd64132;
      6'd21: m = 17'd64248; 6'd22: m = 17'd64364; 6'd23: m = 17'd64480;
      6'd24: m = 17'd64596; 6'd25: m = 17'd64713; 6'd26: m = 17'd64830;
      6'd27: m = 17'd64947; 6'd28: m = 17'd65065; 6'd29: m = 17'd65182;
      6'd30: m = 17'd65300; 6'd31: m = 17'd65418; 6'd32: m = 17'd65536;
      6'd33: m = 17'd65654; 6'd34: m = 17'd65773; 6'd35: m = 17'd65892;
      6'd36: m = 17'd66011; 6'd37: m = 17'd66130; 6'd38: m = 17'd66250;
      6'd39: m = 17'd66369; 6'd40: m = 17'd66489; 6'd41: m = 17'd66609;
      6'd42: m = 17'd66730; 6'd43: m = 17'd66850; 6'd44: m = 17'd66971;
      6'd45: m = 17'd67092; 6'd46: m = 17'd67213; 6'd47: m = 17'd67335;
      6'd48: m = 17'd67456; 6'd49: m = 17'd67578; 6'd50: m = 17'd67700;
      6'd51: m = 17'd67823; 6'd52: m = 17'd67945; 6'd53: m = 17'd68068;
      6'd54: m = 17'd68191; 6'd55: m = 17'd68314; 6'd56: m = 17'd68438;
      6'd57: m = 17'd68561; 6'd58: m = 17'd68685; 6'd59: m = 17'd68809;
      6'd60: m = 17'd68933; 6'd61: m = 17'd69058; 6'd62: m = 17'd69183;
      default: m = 17'd69308;
    endcase
    return m;
  endfunction

endpackage

### src/wtvm_ram.sv
// ----------------------------------------------------------------------------
// wtvm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wtvm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/wavetable_voice_mixer_top.sv
// ----------------------------------------------------------------------------
// wavetable_voice_mixer_top
// Fifteen-voice wavetable synthesizer with a 12-bit mixed output.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_ channel (valid/ready). A tick gives exactly one
//   transfer on the out_ channel; all other commands give none.
//   Voice state (volume, increment, phase) lives in a 15-entry RAM, the wave
//   table in a 1024-entry RAM and the step table in a 128-entry RAM, all with
//   registered reads. Active flags, notes and channels sit in flops.
//   Work per command, from the input transfer until ready again:
//     load wave / load step / dropped note: none beyond the transfer
//     note on, note off: a voice RAM write
//     pitch bend: every voice visited, matching active ones read, scaled, written
//     tick: every voice visited, active ones advanced and summed, then output load
//   The tick walks the voices through the single voice RAM, one
//   read-modify-write per active voice; that walk sets the tick rate.
//   Reset clears all voices and the output valid flag; the wave and step tables
//   keep their contents and must be loaded before use.
//   A finished sample waits in the output register; a new command can be
//   taken while it waits, and a following tick stalls at its end until the
//   receiver takes the earlier sample.
// ----------------------------------------------------------------------------
module wavetable_voice_mixer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_cmd,
  input  logic [3:0]                         in_channel,
  input  logic [6:0]                         in_key,
  input  logic [6:0]                         in_velocity,
  input  logic [13:0]                        in_bend,
  input  logic [9:0]                         in_table_index,
  input  logic signed [15:0]                 in_wave_value,
  input  logic [wtvm_pkg::INC_W-1:0]         in_step_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [11:0]                        out_dac_sample,
  output logic                               out_clipped
);
  import wtvm_pkg::*;

  state_t state_r, state_nxt;

  logic [VOICE_COUNT-1:0] active_r;
  logic [NOTE_AW-1:0]     note_r [VOICE_COUNT];
  logic [3:0]             vchan_r [VOICE_COUNT];

  logic [VOICE_W-1:0]     voice_r;
  logic [VOICE_W-1:0]     tgt_r;
  logic [3:0]             chan_r;
  logic [VOL_W-1:0]       vel_r;
  logic [MULT_W-1:0]      mult_r;
  logic [INC_W+MULT_W-1:0] prod_r;
  logic signed [SUM_W-1:0] sum_r;

  logic        out_valid_r;
  logic [11:0] out_dac_r;
  logic        out_clip_r;

  // memory ports
  logic               vm_we, vm_re;
  logic [VOICE_W-1:0] vm_waddr, vm_raddr;
  voice_t             vm_wdata, vm_rdata;
  logic               wm_we, wm_re;
  logic [WAVE_AW-1:0] wm_raddr;
  logic signed [15:0] wm_rdata;
  logic               sm_we, sm_re;
  logic [NOTE_AW-1:0] sm_raddr;
  logic [INC_W-1:0]   sm_rdata;

  wtvm_ram #(.DEPTH(VOICE_COUNT), .WIDTH($bits(voice_t))) u_voice_ram (
    .clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
    .re(vm_re), .raddr(vm_raddr), .rdata(vm_rdata)
  );

  wtvm_ram #(.DEPTH(WAVE_SIZE), .WIDTH(16)) u_wave_ram (
    .clk(clk), .we(wm_we), .waddr(in_table_index[WAVE_AW-1:0]),
    .wdata(in_wave_value), .re(wm_re), .raddr(wm_raddr), .rdata(wm_rdata)
  );

  wtvm_ram #(.DEPTH(NOTE_COUNT), .WIDTH(INC_W)) u_step_ram (
    .clk(clk), .we(sm_we), .waddr(in_table_index[NOTE_AW-1:0]),
    .wdata(in_step_value), .re(sm_re), .raddr(sm_raddr), .rdata(sm_rdata)
  );

  cmd_t cmd;
  logic accept;
  logic is_release, is_note_on;
  logic free_found, match_found;
  logic [VOICE_W-1:0] free_idx, match_idx;
  logic last_voice;
  logic bend_hit;
  logic [PHASE_W-1:0] new_phase;
  logic signed [23:0] wprod;
  logic signed [SUM_W-1:0] wterm;
  logic signed [14:0] mix;
  logic [INC_W+MULT_W-17:0] bend_sh;
  logic [INC_W-1:0] bend_inc;
  logic out_load;

  assign cmd        = cmd_t'(in_cmd);
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign is_note_on = (cmd == CMD_NOTE_ON) && (in_velocity != '0);
  assign is_release = (cmd == CMD_NOTE_OFF) ||
                      ((cmd == CMD_NOTE_ON) && (in_velocity == '0));
  assign last_voice = (voice_r == VOICE_W'(VOICE_COUNT - 1));
  assign bend_hit   = active_r[voice_r] && (vchan_r[voice_r] == chan_r);

  // lowest free voice and lowest active voice holding the key
  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int n = 0; n < VOICE_COUNT; n++) begin
      if (!free_found && !active_r[n]) begin
        free_found = 1'b1;
        free_idx   = VOICE_W'(n);
      end
      if (!match_found && active_r[n] && (note_r[n] == in_key)) begin
        match_found = 1'b1;
        match_idx   = VOICE_W'(n);
      end
    end
  end

  assign new_phase = vm_rdata.phase + PHASE_W'(vm_rdata.inc);
  assign wprod     = wm_rdata * $signed({1'b0, vm_rdata.vol});
  assign wterm     = SUM_W'(wprod >>> 4);
  assign mix       = 15'(sum_r >>> 10) + 15'sd2048;
  assign bend_sh   = prod_r[INC_W+MULT_W-1:16];
  assign bend_inc  = bend_sh[INC_W] ? {INC_W{1'b1}} : bend_sh[INC_W-1:0];
  assign out_load  = (state_r == S_TICK_OUT) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_TICK:     state_nxt = S_TICK_RD;
            CMD_NOTE_ON,
            CMD_NOTE_OFF: begin
              if (is_note_on && free_found) state_nxt = S_NOTE_ON;
              else if (is_release && match_found) state_nxt = S_REL;
            end
            CMD_BEND:     state_nxt = S_BEND_RD;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_NOTE_ON:  state_nxt = S_IDLE;
      S_REL:      state_nxt = S_IDLE;
      S_BEND_RD: begin
        if (bend_hit) state_nxt = S_BEND_MUL;
        else if (last_voice) state_nxt = S_IDLE;
      end
      S_BEND_MUL: state_nxt = S_BEND_WR;
      S_BEND_WR:  state_nxt = last_voice ? S_IDLE : S_BEND_RD;
      S_TICK_RD: begin
        if (active_r[voice_r]) state_nxt = S_TICK_PH;
        else if (last_voice) state_nxt = S_TICK_OUT;
      end
      S_TICK_PH:  state_nxt = S_TICK_ACC;
      S_TICK_ACC: state_nxt = last_voice ? S_TICK_OUT : S_TICK_RD;
      S_TICK_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    vm_we    = 1'b0;
    vm_waddr = voice_r;
    vm_wdata = vm_rdata;
    vm_re    = 1'b0;
    vm_raddr = voice_r;
    wm_we    = 1'b0;
    wm_re    = 1'b0;
    wm_raddr = new_phase[PHASE_W-1:16];
    sm_we    = 1'b0;
    sm_re    = 1'b0;
    sm_raddr = in_key;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          wm_we = (cmd == CMD_LOAD_WAVE) && ({1'b0, in_table_index} < WAVE_LIMIT);
          sm_we = (cmd == CMD_LOAD_STEP) && ({1'b0, in_table_index} < NOTE_LIMIT);
          sm_re = is_note_on || is_release;
          vm_re = is_release;
          vm_raddr = match_idx;
        end
      end
      S_NOTE_ON: begin
        vm_we    = 1'b1;
        vm_waddr = tgt_r;
        vm_wdata = '{vol: vel_r, inc: sm_rdata, phase: '0};
      end
      S_REL: begin
        vm_we    = 1'b1;
        vm_waddr = tgt_r;
        vm_wdata = '{vol: vm_rdata.vol, inc: sm_rdata, phase: vm_rdata.phase};
      end
      S_BEND_RD: begin
        vm_re    = bend_hit;
        sm_re    = bend_hit;
        sm_raddr = note_r[voice_r];
      end
      S_BEND_WR: begin
        vm_we    = 1'b1;
        vm_wdata = '{vol: vm_rdata.vol, inc: bend_inc, phase: vm_rdata.phase};
      end
      S_TICK_RD: vm_re = active_r[voice_r];
      S_TICK_PH: begin
        vm_we    = 1'b1;
        vm_wdata = '{vol: vm_rdata.vol, inc: vm_rdata.inc, phase: new_phase};
        wm_re    = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      voice_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && is_note_on && free_found) begin
        active_r[free_idx] <= 1'b1;
      end else if (accept && is_release && match_found) begin
        active_r[match_idx] <= 1'b0;
      end
      if (state_r == S_IDLE) begin
        voice_r <= '0;
      end else if (((state_r == S_BEND_RD) && !bend_hit) || (state_r == S_BEND_WR) ||
                   ((state_r == S_TICK_RD) && !active_r[voice_r]) ||
                   (state_r == S_TICK_ACC)) begin
        voice_r <= last_voice ? '0 : voice_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < VOICE_COUNT; n++) begin
        note_r[n]  <= '0;
        vchan_r[n] <= '0;
      end
    end else if (accept && is_note_on && free_found) begin
      note_r[free_idx]  <= in_key;
      vchan_r[free_idx] <= in_channel;
    end else if (accept && is_release && match_found) begin
      note_r[match_idx]  <= in_key;
      vchan_r[match_idx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r <= in_channel;
      vel_r  <= in_velocity;
      mult_r <= bend_mult(in_bend[13:8]);
      tgt_r  <= is_note_on ? free_idx : match_idx;
      sum_r  <= '0;
    end
    if (state_r == S_BEND_MUL) begin
      prod_r <= sm_rdata * mult_r;
    end
    if (state_r == S_TICK_ACC) begin
      sum_r <= sum_r + wterm;
    end
    if (out_load) begin
      if (mix < 0) begin
        out_dac_r  <= '0;
        out_clip_r <= 1'b1;
      end else if (mix > 15'sd4095) begin
        out_dac_r  <= 12'd4095;
        out_clip_r <= 1'b1;
      end else begin
        out_dac_r  <= mix[11:0];
        out_clip_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dac_sample = out_dac_r;
  assign out_clipped    = out_clip_r;

endmodule

### src/wtvm_checker.sv
// ----------------------------------------------------------------------------
// wtvm_checker
// Port-level checks on the mixer's result channel.
// ----------------------------------------------------------------------------
module wtvm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_dac_sample,
  input logic        out_clipped
);

  // a pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dac_sample))
    else $error("result changed before transfer");

  // clipping flag only on a rail value
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_dac_sample == 12'd0) || (out_dac_sample == 12'd4095))
    else $error("clipped sample not at a rail");

  // a new result never directly follows an input transfer
  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too early");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind wavetable_voice_mixer_top wtvm_checker u_wtvm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_dac_sample(out_dac_sample), .out_clipped(out_clipped)
);
